### rtl/hkrd_pkg.sv
package hkrd_pkg;

    // Report geometry
    localparam int KEY_FIELDS = 6;
    localparam int MAX_KEYS   = 6;
    localparam int MOD_BITS   = 8;
    localparam int USAGE_W    = 8;
    localparam int CNT_W      = 3;
    localparam int IDX_W      = 3;

    // Usable key slots: the smaller of MAX_KEYS and the number of key fields
    localparam logic [CNT_W-1:0] KEY_CAP =
        CNT_W'((MAX_KEYS < KEY_FIELDS) ? MAX_KEYS : KEY_FIELDS);

    // Modifier usages are reported from this base upwards
    localparam logic [USAGE_W-1:0] MOD_BASE = 8'hE0;

    typedef logic [USAGE_W-1:0]                  t_key;
    typedef logic [KEY_FIELDS-1:0][USAGE_W-1:0]  t_key_list;
    typedef logic [KEY_FIELDS-1:0]               t_key_mask;
    typedef logic [MOD_BITS-1:0]                 t_mod_mask;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        EV_MOD,
        EV_REL,
        EV_PRS
    } t_kind;

    // Next event chosen by the scheduler
    typedef struct packed {
        logic              any;
        t_kind             kind;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_pick;

endpackage

### rtl/hid_keyboard_report_diff.sv
// HID boot keyboard key change detector. Each accepted beat is either a report
// (modifier byte plus up to six key usages) or a release-all command; the block
// compares it with the keys and modifiers it holds and issues one press or
// release event per output beat, changed modifiers first (usage 0xE0+bit,
// lowest bit first), then releases in held order, then presses in report order;
// release-all issues releases of all held keys and then of all held modifiers.
// The final event of a beat carries o_last_event. An item is handled in steps: the beat
// is accepted, twelve compare lanes find the changes, the single event output register
// drains one event per cycle while the output is not stalled, and a final step finds
// nothing left and commits the held set. The input stalls until the item is finished.
module hid_keyboard_report_diff (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_mode,
    input  logic [hkrd_pkg::MOD_BITS-1:0]       i_modifier_bits,
    input  logic [hkrd_pkg::CNT_W-1:0]          i_key_count,
    input  logic [hkrd_pkg::USAGE_W-1:0]        i_key_0,
    input  logic [hkrd_pkg::USAGE_W-1:0]        i_key_1,
    input  logic [hkrd_pkg::USAGE_W-1:0]        i_key_2,
    input  logic [hkrd_pkg::USAGE_W-1:0]        i_key_3,
    input  logic [hkrd_pkg::USAGE_W-1:0]        i_key_4,
    input  logic [hkrd_pkg::USAGE_W-1:0]        i_key_5,
    // event channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [hkrd_pkg::USAGE_W-1:0]        o_usage_code,
    output logic                                o_is_press,
    output logic [hkrd_pkg::MOD_BITS-1:0]       o_modifier_state,
    output logic                                o_last_event
);

    // Control state
    hkrd_pkg::t_state              r_state, n_state;
    logic                          r_base, n_base;
    logic [hkrd_pkg::CNT_W-1:0]    r_held_cnt, n_held_cnt;
    hkrd_pkg::t_mod_mask           r_mods, n_mods;
    hkrd_pkg::t_mod_mask           r_mod_mask, n_mod_mask;
    hkrd_pkg::t_key_mask           r_rel_mask, n_rel_mask;
    hkrd_pkg::t_key_mask           r_prs_mask, n_prs_mask;
    logic                          r_o_valid, n_o_valid;

    // Payload
    hkrd_pkg::t_key_list           r_held, n_held;
    logic                          r_mode, n_mode;
    hkrd_pkg::t_mod_mask           r_in_mods, n_in_mods;
    logic [hkrd_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    hkrd_pkg::t_key_list           r_keys, n_keys;
    logic [hkrd_pkg::USAGE_W-1:0]  r_usage, n_usage;
    logic                          r_press, n_press;
    hkrd_pkg::t_mod_mask           r_mstate, n_mstate;
    logic                          r_last, n_last;

    logic                          in_acc;
    logic                          out_free;
    hkrd_pkg::t_key_mask           still_held;
    hkrd_pkg::t_key_mask           was_held;
    hkrd_pkg::t_pick               pick;
    hkrd_pkg::t_mod_mask           base_mods;
    hkrd_pkg::t_mod_mask           mod_next;

    assign o_stall  = (r_state != hkrd_pkg::ST_IDLE);
    assign in_acc   = i_valid & ~o_stall;
    assign out_free = ~r_o_valid | ~i_stall;

    // Compare lanes: held keys against the new report, new keys against held set
    for (genvar g = 0; g < hkrd_pkg::KEY_FIELDS; g++) begin : g_lane
        hkrd_lane u_rel_lane (
            .i_probe (r_held[g]),
            .i_list  (r_keys),
            .i_count (r_cnt),
            .o_found (still_held[g])
        );
        hkrd_lane u_prs_lane (
            .i_probe (r_keys[g]),
            .i_list  (r_held),
            .i_count (r_held_cnt),
            .o_found (was_held[g])
        );
    end

    hkrd_sched u_sched (
        .i_mode     (r_mode),
        .i_mod_mask (r_mod_mask),
        .i_rel_mask (r_rel_mask),
        .i_prs_mask (r_prs_mask),
        .o_pick     (pick)
    );

    // Modifier baseline: the first report only records its modifier byte
    assign base_mods = r_base ? r_mods : r_in_mods;

    // Modifier state after the picked modifier event
    always_comb begin
        mod_next = r_mods;
        mod_next[pick.idx] = r_mode ? 1'b0 : r_in_mods[pick.idx];
    end

    // Next state and datapath
    always_comb begin
        n_state    = r_state;
        n_base     = r_base;
        n_held_cnt = r_held_cnt;
        n_mods     = r_mods;
        n_mod_mask = r_mod_mask;
        n_rel_mask = r_rel_mask;
        n_prs_mask = r_prs_mask;
        n_held     = r_held;
        n_mode     = r_mode;
        n_in_mods  = r_in_mods;
        n_cnt      = r_cnt;
        n_keys     = r_keys;
        n_usage    = r_usage;
        n_press    = r_press;
        n_mstate   = r_mstate;
        n_last     = r_last;
        n_o_valid  = r_o_valid & i_stall;

        unique case (r_state)
            hkrd_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_mode    = i_mode;
                    n_in_mods = i_modifier_bits;
                    n_cnt     = (i_key_count > hkrd_pkg::KEY_CAP) ? hkrd_pkg::KEY_CAP
                                                                  : i_key_count;
                    n_keys    = {i_key_5, i_key_4, i_key_3, i_key_2, i_key_1, i_key_0};
                    n_state   = hkrd_pkg::ST_DIFF;
                end
            end
            hkrd_pkg::ST_DIFF: begin
                if (r_mode) begin
                    n_mod_mask = r_mods;
                    n_prs_mask = '0;
                    for (int i = 0; i < hkrd_pkg::KEY_FIELDS; i++) begin
                        n_rel_mask[i] = (hkrd_pkg::CNT_W'(i) < r_held_cnt);
                    end
                end else begin
                    n_mods     = base_mods;
                    n_base     = 1'b1;
                    n_mod_mask = base_mods ^ r_in_mods;
                    for (int i = 0; i < hkrd_pkg::KEY_FIELDS; i++) begin
                        n_rel_mask[i] = (hkrd_pkg::CNT_W'(i) < r_held_cnt) & ~still_held[i];
                        n_prs_mask[i] = (hkrd_pkg::CNT_W'(i) < r_cnt) & ~was_held[i];
                    end
                end
                n_state = hkrd_pkg::ST_EMIT;
            end
            hkrd_pkg::ST_EMIT: begin
                if (!pick.any) begin
                    // Item finished: a report becomes the held set; release-all clears it
                    if (r_mode) begin
                        n_held_cnt = '0;
                        n_mods     = '0;
                        n_base     = 1'b0;
                    end else begin
                        n_held     = r_keys;
                        n_held_cnt = r_cnt;
                    end
                    n_state = hkrd_pkg::ST_IDLE;
                end else if (out_free) begin
                    n_o_valid = 1'b1;
                    n_last    = pick.last;
                    n_mstate  = r_mods;
                    unique case (pick.kind)
                        hkrd_pkg::EV_MOD: begin
                            n_usage  = hkrd_pkg::MOD_BASE
                                     + hkrd_pkg::USAGE_W'(pick.idx);
                            n_press  = r_mode ? 1'b0 : r_in_mods[pick.idx];
                            n_mods   = mod_next;
                            n_mstate = mod_next;
                            n_mod_mask[pick.idx] = 1'b0;
                        end
                        hkrd_pkg::EV_REL: begin
                            n_usage = r_held[pick.idx];
                            n_press = 1'b0;
                            n_rel_mask[pick.idx] = 1'b0;
                        end
                        hkrd_pkg::EV_PRS: begin
                            n_usage = r_keys[pick.idx];
                            n_press = 1'b1;
                            n_prs_mask[pick.idx] = 1'b0;
                        end
                        default: begin
                            n_o_valid = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                n_state = hkrd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= hkrd_pkg::ST_IDLE;
            r_base     <= 1'b0;
            r_held_cnt <= '0;
            r_mods     <= '0;
            r_mod_mask <= '0;
            r_rel_mask <= '0;
            r_prs_mask <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_base     <= n_base;
            r_held_cnt <= n_held_cnt;
            r_mods     <= n_mods;
            r_mod_mask <= n_mod_mask;
            r_rel_mask <= n_rel_mask;
            r_prs_mask <= n_prs_mask;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_held    <= n_held;
        r_mode    <= n_mode;
        r_in_mods <= n_in_mods;
        r_cnt     <= n_cnt;
        r_keys    <= n_keys;
        r_usage   <= n_usage;
        r_press   <= n_press;
        r_mstate  <= n_mstate;
        r_last    <= n_last;
    end

    assign o_valid          = r_o_valid;
    assign o_usage_code     = r_usage;
    assign o_is_press       = r_press;
    assign o_modifier_state = r_mstate;
    assign o_last_event     = r_last;

    // Checks
    a_accept_to_diff : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == hkrd_pkg::ST_DIFF))
        else $error("accepted beat did not start a compare");

    a_held_cnt_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_cnt <= hkrd_pkg::KEY_CAP)
        else $error("held key count beyond capacity");

    a_last_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hkrd_pkg::ST_EMIT && pick.any && out_free && pick.last)
        |=> (r_mod_mask == '0 && r_rel_mask == '0 && r_prs_mask == '0))
        else $error("events pending after final event");

    a_release_all_mods : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hkrd_pkg::ST_EMIT && pick.any && out_free && pick.last && r_mode)
        |=> (o_modifier_state == '0))
        else $error("modifiers still held after release-all");

    a_no_event_outside : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != hkrd_pkg::ST_EMIT) |=> !$rose(o_valid))
        else $error("event issued outside emit phase");

endmodule

### rtl/hkrd_lane.sv
// One compare lane: is the probe key among the first i_count entries of the list?
module hkrd_lane (
    input  hkrd_pkg::t_key                 i_probe,
    input  hkrd_pkg::t_key_list            i_list,
    input  logic [hkrd_pkg::CNT_W-1:0]     i_count,
    output logic                           o_found
);

    always_comb begin
        o_found = 1'b0;
        for (int j = 0; j < hkrd_pkg::KEY_FIELDS; j++) begin
            if ((hkrd_pkg::CNT_W'(j) < i_count) && (i_list[j] == i_probe)) begin
                o_found = 1'b1;
            end
        end
    end

endmodule

### rtl/hkrd_sched.sv
// Merge stage: picks the next event from the pending masks, lowest index first
// within each mask, and flags whether it is the final one.
module hkrd_sched (
    input  logic                   i_mode,
    input  hkrd_pkg::t_mod_mask    i_mod_mask,
    input  hkrd_pkg::t_key_mask    i_rel_mask,
    input  hkrd_pkg::t_key_mask    i_prs_mask,
    output hkrd_pkg::t_pick        o_pick
);

    logic [hkrd_pkg::IDX_W-1:0] mod_idx;
    logic [hkrd_pkg::IDX_W-1:0] rel_idx;
    logic [hkrd_pkg::IDX_W-1:0] prs_idx;
    logic                       mod_any;
    logic                       rel_any;
    logic                       prs_any;
    logic [hkrd_pkg::MOD_BITS-1:0]   mod_left;
    logic [hkrd_pkg::KEY_FIELDS-1:0] rel_left;
    logic [hkrd_pkg::KEY_FIELDS-1:0] prs_left;

    // Lowest set bit of each mask
    always_comb begin
        mod_idx = '0;
        rel_idx = '0;
        prs_idx = '0;
        for (int i = hkrd_pkg::MOD_BITS - 1; i >= 0; i--) begin
            if (i_mod_mask[i]) mod_idx = hkrd_pkg::IDX_W'(i);
        end
        for (int i = hkrd_pkg::KEY_FIELDS - 1; i >= 0; i--) begin
            if (i_rel_mask[i]) rel_idx = hkrd_pkg::IDX_W'(i);
            if (i_prs_mask[i]) prs_idx = hkrd_pkg::IDX_W'(i);
        end
    end

    assign mod_any = |i_mod_mask;
    assign rel_any = |i_rel_mask;
    assign prs_any = |i_prs_mask;

    // Order: modifiers, releases, presses; release-all puts keys before modifiers
    always_comb begin
        mod_left    = i_mod_mask;
        rel_left    = i_rel_mask;
        prs_left    = i_prs_mask;
        o_pick.any  = mod_any | rel_any | prs_any;
        o_pick.kind = hkrd_pkg::EV_MOD;
        o_pick.idx  = mod_idx;
        if (i_mode) begin
            if (rel_any) begin
                o_pick.kind = hkrd_pkg::EV_REL;
                o_pick.idx  = rel_idx;
                rel_left[rel_idx] = 1'b0;
            end else begin
                mod_left[mod_idx] = 1'b0;
            end
        end else begin
            priority if (mod_any) begin
                mod_left[mod_idx] = 1'b0;
            end else if (rel_any) begin
                o_pick.kind = hkrd_pkg::EV_REL;
                o_pick.idx  = rel_idx;
                rel_left[rel_idx] = 1'b0;
            end else begin
                o_pick.kind = hkrd_pkg::EV_PRS;
                o_pick.idx  = prs_idx;
                prs_left[prs_idx] = 1'b0;
            end
        end
        o_pick.last = ~(|mod_left | |rel_left | |prs_left);
    end

endmodule

### tb/sv/tb_hid_keyboard_report_diff.sv
`timescale 1ns / 100ps

module tb_hid_keyboard_report_diff;

    // Beat codes on the mode field
    localparam logic MODE_REPORT      = 1'b0;
    localparam logic MODE_RELEASE_ALL = 1'b1;

    localparam int RANDOM_REPORTS = 85;
    localparam int CALM_TAIL      = 20;   // beats left when idling stops
    localparam int DRAIN_CYCLES   = 30;   // extra wait after the last event
    localparam int SHOWN_FAULTS   = 10;

    typedef struct packed {
        logic                        mode;
        hkrd_pkg::t_mod_mask         mods;
        logic [hkrd_pkg::CNT_W-1:0]  cnt;
        hkrd_pkg::t_key_list         keys;
    } t_report_beat;

    typedef struct packed {
        hkrd_pkg::t_key       usage;
        logic                 press;
        hkrd_pkg::t_mod_mask  mods;
        logic                 last;
    } t_key_event;

    logic                          i_clk            = 1'b0;
    logic                          i_rst_n          = 1'b0;
    logic                          i_valid          = 1'b0;
    logic                          o_stall;
    logic                          i_mode           = MODE_REPORT;
    logic [hkrd_pkg::MOD_BITS-1:0] i_modifier_bits  = '0;
    logic [hkrd_pkg::CNT_W-1:0]    i_key_count      = '0;
    logic [hkrd_pkg::USAGE_W-1:0]  i_key_0          = '0;
    logic [hkrd_pkg::USAGE_W-1:0]  i_key_1          = '0;
    logic [hkrd_pkg::USAGE_W-1:0]  i_key_2          = '0;
    logic [hkrd_pkg::USAGE_W-1:0]  i_key_3          = '0;
    logic [hkrd_pkg::USAGE_W-1:0]  i_key_4          = '0;
    logic [hkrd_pkg::USAGE_W-1:0]  i_key_5          = '0;
    logic                          o_valid;
    logic                          i_stall          = 1'b0;
    logic [hkrd_pkg::USAGE_W-1:0]  o_usage_code;
    logic                          o_is_press;
    logic [hkrd_pkg::MOD_BITS-1:0] o_modifier_state;
    logic                          o_last_event;

    hid_keyboard_report_diff DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_modifier_bits  (i_modifier_bits),
        .i_key_count      (i_key_count),
        .i_key_0          (i_key_0),
        .i_key_1          (i_key_1),
        .i_key_2          (i_key_2),
        .i_key_3          (i_key_3),
        .i_key_4          (i_key_4),
        .i_key_5          (i_key_5),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_usage_code     (o_usage_code),
        .o_is_press       (o_is_press),
        .o_modifier_state (o_modifier_state),
        .o_last_event     (o_last_event)
    );

    t_report_beat report_queue[$];
    t_key_event   pending_events[$];
    t_report_beat driven_beat;
    t_report_beat next_beat;
    int           beats_taken = 0;
    int           total_beats = 0;
    int           fault_count = 0;
    int           send_gap    = 0;
    int           stall_hold  = 0;
    logic         calm        = 1'b0;

    // Shadow of the key tracker
    hkrd_pkg::t_key_list    held_keys;
    int                     held_count;
    hkrd_pkg::t_mod_mask    held_mods;
    logic                   baseline_done;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Record an event with the modifier state as it stands now
    function automatic void add_event(ref t_key_event evs[$], input hkrd_pkg::t_key usage,
                                      input logic press);
        evs.push_back('{usage: usage, press: press, mods: held_mods, last: 1'b0});
    endfunction

    // Work out the events one beat causes and update the shadow state
    function automatic void diff_report(input t_report_beat b);
        t_key_event           evs[$];
        hkrd_pkg::t_mod_mask  changed;
        int                   n_keys;
        logic                 found;
        if (b.mode == MODE_RELEASE_ALL) begin
            for (int i = 0; i < held_count; i++)
                add_event(evs, held_keys[i], 1'b0);
            held_count = 0;
            for (int i = 0; i < hkrd_pkg::MOD_BITS; i++) begin
                if (held_mods[i]) begin
                    held_mods[i] = 1'b0;
                    add_event(evs, hkrd_pkg::MOD_BASE + hkrd_pkg::t_key'(i), 1'b0);
                end
            end
            held_mods     = '0;
            baseline_done = 1'b0;
        end else begin
            n_keys = (b.cnt > hkrd_pkg::KEY_CAP) ? int'(hkrd_pkg::KEY_CAP) : int'(b.cnt);
            // first report only sets the modifier baseline
            if (!baseline_done) begin
                baseline_done = 1'b1;
                held_mods     = b.mods;
            end
            changed = held_mods ^ b.mods;
            for (int i = 0; i < hkrd_pkg::MOD_BITS; i++) begin
                if (changed[i]) begin
                    held_mods[i] = b.mods[i];
                    add_event(evs, hkrd_pkg::MOD_BASE + hkrd_pkg::t_key'(i), b.mods[i]);
                end
            end
            // releases in held order
            for (int i = 0; i < held_count; i++) begin
                found = 1'b0;
                for (int j = 0; j < n_keys; j++)
                    if (held_keys[i] == b.keys[j]) found = 1'b1;
                if (!found) add_event(evs, held_keys[i], 1'b0);
            end
            // presses in report order, one per copy
            for (int i = 0; i < n_keys; i++) begin
                found = 1'b0;
                for (int j = 0; j < held_count; j++)
                    if (b.keys[i] == held_keys[j]) found = 1'b1;
                if (!found) add_event(evs, b.keys[i], 1'b1);
            end
            for (int i = 0; i < n_keys; i++)
                held_keys[i] = b.keys[i];
            held_count = n_keys;
        end
        if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
        foreach (evs[k]) pending_events.push_back(evs[k]);
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= SHOWN_FAULTS) $display("%0t: %s", $realtime, msg);
    endfunction

    function automatic void push_report(input logic mode, input hkrd_pkg::t_mod_mask mods,
                                        input int cnt, input hkrd_pkg::t_key k0,
                                        input hkrd_pkg::t_key k1, input hkrd_pkg::t_key k2,
                                        input hkrd_pkg::t_key k3, input hkrd_pkg::t_key k4,
                                        input hkrd_pkg::t_key k5);
        t_report_beat b;
        b.mode = mode;
        b.mods = mods;
        b.cnt  = hkrd_pkg::CNT_W'(cnt);
        b.keys = {k5, k4, k3, k2, k1, k0};
        report_queue.push_back(b);
    endfunction

    // Mostly a small pool so reports overlap; now and then any code
    function automatic hkrd_pkg::t_key draw_usage();
        if ($urandom_range(0, 9) == 0) return hkrd_pkg::t_key'($urandom_range(0, 255));
        return hkrd_pkg::t_key'($urandom_range(4, 15));
    endfunction

    // Input driver: one beat per handshake, random idle bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid       <= 1'b0;
            send_gap      <= 0;
            calm          <= 1'b0;
            held_keys     = '0;
            held_count    = 0;
            held_mods     = '0;
            baseline_done = 1'b0;
        end else begin
            calm <= (report_queue.size() <= CALM_TAIL);
            if (i_valid && !o_stall) begin
                diff_report(driven_beat);
                beats_taken <= beats_taken + 1;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(1, 19) - 1;
                    i_valid  <= 1'b0;
                end else if (report_queue.size() > 0) begin
                    next_beat       = report_queue.pop_front();
                    driven_beat     <= next_beat;
                    i_valid         <= 1'b1;
                    i_mode          <= next_beat.mode;
                    i_modifier_bits <= next_beat.mods;
                    i_key_count     <= next_beat.cnt;
                    i_key_0         <= next_beat.keys[0];
                    i_key_1         <= next_beat.keys[1];
                    i_key_2         <= next_beat.keys[2];
                    i_key_3         <= next_beat.keys[3];
                    i_key_4         <= next_beat.keys[4];
                    i_key_5         <= next_beat.keys[5];
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Event monitor: check each beat, stall in random bursts
    always @(posedge i_clk) begin
        t_key_event seen;
        t_key_event want;
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_hold <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                seen = '{usage: o_usage_code, press: o_is_press,
                         mods: o_modifier_state, last: o_last_event};
                if (pending_events.size() == 0) begin
                    note_fault($sformatf(
                        "unexpected event usage=%02h press=%0b mods=%02h last=%0b",
                        seen.usage, seen.press, seen.mods, seen.last));
                end else begin
                    want = pending_events.pop_front();
                    if (seen.usage !== want.usage || seen.press !== want.press ||
                        seen.mods !== want.mods || seen.last !== want.last)
                        note_fault($sformatf({"event mismatch: exp usage=%02h press=%0b ",
                            "mods=%02h last=%0b, got usage=%02h press=%0b mods=%02h last=%0b"},
                            want.usage, want.press, want.mods, want.last,
                            seen.usage, seen.press, seen.mods, seen.last));
                end
            end
            if (stall_hold > 0) begin
                stall_hold <= stall_hold - 1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_stall    <= 1'b1;
                stall_hold <= $urandom_range(1, 19) - 1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        hkrd_pkg::t_mod_mask gen_mods;
        hkrd_pkg::t_key_list gen_keys;
        int                  gen_cnt;
        int                  slot;
        int                  cnt_out;

        // Directed: empty release-all, baseline, no change, all modifiers flipping
        push_report(MODE_RELEASE_ALL, 8'hFF, 7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_report(MODE_REPORT, 8'hA5, 3, 8'h04, 8'h05, 8'h06, 8'hFF, 8'hFF, 8'hFF);
        push_report(MODE_REPORT, 8'hA5, 3, 8'h04, 8'h05, 8'h06, 8'hFF, 8'hFF, 8'hFF);
        push_report(MODE_REPORT, 8'h5A, 6, 8'h05, 8'h00, 8'hFF, 8'h07, 8'h08, 8'h09);
        // oversized count saturates
        push_report(MODE_REPORT, 8'hFF, 7, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15);
        // duplicated usages
        push_report(MODE_REPORT, 8'h00, 6, 8'h20, 8'h20, 8'h20, 8'h21, 8'h21, 8'h22);
        push_report(MODE_REPORT, 8'h00, 0, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA);
        push_report(MODE_REPORT, 8'hFF, 6, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35);
        push_report(MODE_RELEASE_ALL, 8'h00, 0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        push_report(MODE_REPORT, 8'hFF, 6, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35);
        // longest burst: every modifier and every key changes
        push_report(MODE_REPORT, 8'h00, 6, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45);
        push_report(MODE_REPORT, 8'h01, 1, 8'h00, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45);
        push_report(MODE_REPORT, 8'h80, 2, 8'h00, 8'hFF, 8'h42, 8'h43, 8'h44, 8'h45);
        // release-all ignores its other fields
        push_report(MODE_RELEASE_ALL, 8'h5A, 3, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC);
        push_report(MODE_REPORT, 8'h00, 5, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hE0);

        // Random: mostly evolving reports, some noise and release-all
        gen_mods = '0;
        gen_keys = '0;
        gen_cnt  = 0;
        for (int n = 0; n < RANDOM_REPORTS; n++) begin
            slot = $urandom_range(0, 99);
            if (slot < 6) begin
                push_report(MODE_RELEASE_ALL, hkrd_pkg::t_mod_mask'($urandom),
                            $urandom_range(0, 7),
                            hkrd_pkg::t_key'($urandom), hkrd_pkg::t_key'($urandom),
                            hkrd_pkg::t_key'($urandom), hkrd_pkg::t_key'($urandom),
                            hkrd_pkg::t_key'($urandom), hkrd_pkg::t_key'($urandom));
            end else if (slot < 14) begin
                push_report(MODE_REPORT, hkrd_pkg::t_mod_mask'($urandom),
                            $urandom_range(0, 7),
                            hkrd_pkg::t_key'($urandom), hkrd_pkg::t_key'($urandom),
                            hkrd_pkg::t_key'($urandom), hkrd_pkg::t_key'($urandom),
                            hkrd_pkg::t_key'($urandom), hkrd_pkg::t_key'($urandom));
            end else begin
                case ($urandom_range(0, 3))
                    1: gen_mods[$urandom_range(0, 7)] ^= 1'b1;
                    2: gen_mods ^= hkrd_pkg::t_mod_mask'($urandom & $urandom);
                    3: gen_mods = hkrd_pkg::t_mod_mask'($urandom);
                    default: ;
                endcase
                case ($urandom_range(0, 3))
                    0: if (gen_cnt > 0) begin
                        slot = $urandom_range(0, gen_cnt - 1);
                        for (int s = slot; s < hkrd_pkg::KEY_FIELDS - 1; s++)
                            gen_keys[s] = gen_keys[s+1];
                        gen_cnt--;
                    end
                    1: if (gen_cnt < hkrd_pkg::KEY_FIELDS) begin
                        gen_keys[gen_cnt] = draw_usage();
                        gen_cnt++;
                    end
                    2: if (gen_cnt > 0) gen_keys[$urandom_range(0, gen_cnt - 1)] = draw_usage();
                    default: ;
                endcase
                // unused slots carry junk
                for (int s = gen_cnt; s < hkrd_pkg::KEY_FIELDS; s++)
                    gen_keys[s] = hkrd_pkg::t_key'($urandom);
                cnt_out = (gen_cnt == hkrd_pkg::KEY_FIELDS && $urandom_range(0, 3) == 0)
                        ? 7 : gen_cnt;
                push_report(MODE_REPORT, gen_mods, cnt_out, gen_keys[0], gen_keys[1],
                            gen_keys[2], gen_keys[3], gen_keys[4], gen_keys[5]);
            end
        end
        total_beats = report_queue.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_taken < total_beats) @(negedge i_clk);
        while (pending_events.size() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fault_count == 0 && pending_events.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
